@@ rtl/susb_pkg.sv @@
package susb_pkg;

	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] set_value;
		logic                      set_last;
		logic [COUNT_W-1:0]        unique_count;
		logic                      overflow;
	} out_item_t;

	// queue head as seen by the sorter
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} queue_head_t;

endpackage

@@ rtl/sort_unique_set_builder_core.sv @@
// Sorted distinct-value set builder.
// Input channel (in_valid/in_ready/in_data): one signed 32-bit value per item;
// is_last marks the end of a list. A 4-entry queue absorbs input items so the
// sender keeps going while the sorter is busy.
// The sorter holds up to MAX_ELEMENTS distinct values in a row of compare
// cells kept in ascending order; while it loads, one queued item is inserted
// per cycle, and duplicates are absorbed. A new distinct value arriving with
// the store full is dropped and sets overflow for that list.
// After the is_last item is taken, the set streams out on the output channel
// (out_valid/out_ready/out_data), smallest first, one item per cycle while the
// receiver is ready, set_last on the largest, with unique_count and overflow on
// every item. An accepted item is registered in the queue before the sorter
// sees it; the first result is registered in the output register once the
// state register has turned to emission. While a set is emitted, the queue
// fills but no item is inserted.
// A stalled receiver freezes emission; the output register holds its item.
// Reset clears the queue, the fill count and the overflow flag; stored
// values need no clearing.
module sort_unique_set_builder_core
	import susb_pkg::*;
#(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	queue_head_t head;
	logic        pop;

	susb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	susb_sorter #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_sorter (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ rtl/susb_front.sv @@
module susb_front
	import susb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output queue_head_t head,
	input  logic        pop
);

	localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

	in_item_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              do_pop;

	assign in_ready   = (count_q != DEPTH_CNT);
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/susb_sorter.sv @@
module susb_sorter
	import susb_pkg::*;
#(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
	localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(MAX_ELEMENTS);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic signed [VALUE_W-1:0] cell_q [MAX_ELEMENTS];
	logic [FILL_W-1:0]         fill_q;
	logic [FILL_W-1:0]         total_q;
	logic                      dropped_q;
	logic                      state_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	logic [MAX_ELEMENTS-1:0]   lt;
	logic [MAX_ELEMENTS-1:0]   eq;
	logic                      dup;
	logic                      full;
	logic                      do_insert;
	logic                      emit_adv;
	logic [FILL_W-1:0]         fill_next;
	logic                      ordered_ok;

	// every cell compares itself against the incoming value in parallel
	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			lt[i] = (FILL_W'(i) < fill_q) && (cell_q[i] < head.item.value);
			eq[i] = (FILL_W'(i) < fill_q) && (cell_q[i] == head.item.value);
		end
	end

	assign dup       = |eq;
	assign full      = (fill_q == FULL_CNT);
	assign pop       = (state_q == ST_LOAD);
	assign do_insert = pop && head.valid && !dup && !full;
	assign fill_next = do_insert ? fill_q + 1'b1 : fill_q;
	assign emit_adv  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert && !lt[g]) begin
				if (g == 0) begin
					cell_q[g] <= head.item.value;
				end else if (lt[(g == 0) ? 0 : g-1]) begin
					cell_q[g] <= head.item.value;
				end else begin
					cell_q[g] <= cell_q[(g == 0) ? 0 : g-1];
				end
			end else if (emit_adv && (g < MAX_ELEMENTS - 1)) begin
				// smallest value leaves at cell 0
				cell_q[g] <= cell_q[(g < MAX_ELEMENTS - 1) ? g+1 : g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_adv) begin
			out_q.set_value    <= cell_q[0];
			out_q.set_last     <= (fill_q == FILL_W'(1));
			out_q.unique_count <= COUNT_W'(total_q);
			out_q.overflow     <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			total_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (head.valid) begin
						fill_q <= fill_next;
						if (!dup && full) begin
							dropped_q <= 1'b1;
						end
						if (head.item.is_last) begin
							total_q <= fill_next;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_adv) begin
						fill_q <= fill_q - 1'b1;
						if (fill_q == FILL_W'(1)) begin
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		ordered_ok = 1'b1;
		for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
			if ((FILL_W'(i + 1) < fill_q) && !(cell_q[i] < cell_q[i+1])) begin
				ordered_ok = 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> fill_q != '0)
		else $error("emitting from an empty store");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit_adv && fill_q == FILL_W'(1) |=> state_q == ST_LOAD && fill_q == '0 && !dropped_q)
		else $error("store not cleared after final result");

	a_store_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		ordered_ok)
		else $error("store not strictly ascending");

endmodule
